FILE: rtl/lav_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lav_pkg: shared widths, latencies and types
// Fixed-point formats and pipeline depths used by the look-at view matrix.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int LAV_W       = 32;
  localparam int LAV_IN_W    = 9 * LAV_W;
  localparam int LAV_OUT_W   = 12 * LAV_W;
  localparam int LAV_FRAC    = 30;
  localparam int LAV_NRM_W   = LAV_FRAC + 1;
  localparam int LAV_ROOT_W  = 32;
  localparam int LAV_SQ_W    = 2 * LAV_ROOT_W;
  localparam int LAV_QUO_W   = LAV_FRAC + 1;
  localparam int LAV_NUM_W   = LAV_NRM_W + LAV_FRAC + 1;
  localparam int LAV_FWD_W   = LAV_W + 1;
  localparam int LAV_XP_W    = 2 * LAV_W - 2;
  localparam int LAV_XW      = LAV_XP_W + 1;
  localparam int LAV_STEPS   = 4;
  localparam int LAV_UNIT_FIX = 7;
  localparam int LAV_CRS_LAT = 2;
  localparam int LAV_RND_LAT = 1;
  localparam int LAV_DOT_LAT = 3;

  localparam logic [63:0] LAV_HALF = 64'd1 << (LAV_FRAC - 1);

  typedef logic signed [LAV_W-1:0] lav_q_t;

endpackage
`default_nettype wire

FILE: rtl/look_at_view_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// look_at_view_matrix: camera view matrix from eye, target and up vectors
// Normalizes forward and up, forms side and true up by cross products and
// gives the rotation rows in Q1.30 with the translation column in Q16.16.
//
// Channel  Side    Payload, lowest bits first, 32 bits per field
// in_*     slave   eye_x..z, target_x..z, upvec_x..z (Q16.16)
// out_*    master  side_x..z, true_up_x..z, back_x..z (Q1.30), shift_x..z
//
// One request is taken per cycle while the output buffer has a free slot. The
// pipeline depth, with the default of four root and quotient bits per stage, is
// set by the square-root and divider stages of the two chained normalizers.
// The pipeline moves while the two-entry output buffer has a free slot, so
// in_tready depends only on registers. Reset empties the pipeline and buffer.
// ----------------------------------------------------------------------------
module look_at_view_matrix #(
  parameter int STEPS = lav_pkg::LAV_STEPS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
  input  logic [lav_pkg::LAV_IN_W-1:0]    in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // side_x, side_y, side_z, true_up_x, true_up_y, true_up_z, back_x, back_y,
  // back_z, shift_x, shift_y, shift_z
  output logic [lav_pkg::LAV_OUT_W-1:0]   out_tdata
);
  import lav_pkg::*;

  localparam int ISQ_STG = (LAV_ROOT_W + STEPS - 1) / STEPS;
  localparam int DIV_STG = (LAV_QUO_W + STEPS - 1) / STEPS;
  localparam int UL      = LAV_UNIT_FIX + ISQ_STG + DIV_STG;
  localparam int T_SIDE  = 2 * UL + LAV_CRS_LAT;
  localparam int T_TU    = T_SIDE + LAV_CRS_LAT + LAV_RND_LAT;
  localparam int T_OUT   = T_TU + LAV_DOT_LAT;
  localparam int RQW     = LAV_XW - LAV_FRAC;
  localparam logic [RQW-1:0] ONE_Q = RQW'(1) << LAV_FRAC;

  logic                      en;
  logic [T_OUT:0]            v_r;
  lav_q_t                    in_eye [3];
  lav_q_t                    in_tgt [3];
  lav_q_t                    in_up  [3];
  lav_q_t                    eye0_r [3];
  logic signed [LAV_FWD_W-1:0] fwd0_r [3];
  lav_q_t                    up0_r  [3];
  lav_q_t                    fwd_u  [3];
  lav_q_t                    up_u   [3];
  logic signed [LAV_XW-1:0]  sraw   [3];
  lav_q_t                    side_u [3];
  logic [3*LAV_W-1:0]        fwd_dv;
  lav_q_t                    fwd_d  [3];
  logic signed [LAV_XW-1:0]  traw   [3];
  lav_q_t                    tu_nxt [3];
  lav_q_t                    tu_r   [3];
  logic [3*LAV_W-1:0]        eye_dv;
  lav_q_t                    eye_d  [3];
  logic [3*LAV_W-1:0]        side_dv;
  lav_q_t                    side_d [3];
  logic [3*LAV_W-1:0]        back_dv;
  lav_q_t                    back_d [3];
  lav_q_t                    shf    [3];
  logic [9*LAV_W-1:0]        rows_o;
  logic [LAV_OUT_W-1:0]      res;
  logic [LAV_OUT_W-1:0]      ob_r [2];
  logic [1:0]                ob_cnt_r;
  logic                      push;
  logic                      pop;

  assign en        = (ob_cnt_r != 2'd2);
  assign in_tready = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_eye[i] = in_tdata[i*LAV_W +: LAV_W];
      in_tgt[i] = in_tdata[(3+i)*LAV_W +: LAV_W];
      in_up[i]  = in_tdata[(6+i)*LAV_W +: LAV_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[T_OUT-1:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        eye0_r[i] <= in_eye[i];
        fwd0_r[i] <= LAV_FWD_W'(in_tgt[i]) - LAV_FWD_W'(in_eye[i]);
        up0_r[i]  <= in_up[i];
        tu_r[i]   <= tu_nxt[i];
      end
    end
  end

  lav_unit3 #(.IW(LAV_FWD_W), .STEPS(STEPS)) u_fwd (
    .clk(clk), .en(en), .v(fwd0_r), .o(fwd_u)
  );

  lav_unit3 #(.IW(LAV_W), .STEPS(STEPS)) u_up (
    .clk(clk), .en(en), .v(up0_r), .o(up_u)
  );

  lav_cross u_cross_side (
    .clk(clk), .en(en), .a(fwd_u), .b(up_u), .o(sraw)
  );

  lav_unit3 #(.IW(LAV_XW), .STEPS(STEPS)) u_side (
    .clk(clk), .en(en), .v(sraw), .o(side_u)
  );

  lav_delay #(.W(3 * LAV_W), .D(T_SIDE - UL)) u_fwd_dly (
    .clk(clk), .en(en), .din({fwd_u[2], fwd_u[1], fwd_u[0]}), .dout(fwd_dv)
  );

  lav_delay #(.W(3 * LAV_W), .D(T_TU - UL)) u_back_dly (
    .clk(clk), .en(en), .din({-fwd_u[2], -fwd_u[1], -fwd_u[0]}), .dout(back_dv)
  );

  lav_delay #(.W(3 * LAV_W), .D(T_TU)) u_eye_dly (
    .clk(clk), .en(en), .din({eye0_r[2], eye0_r[1], eye0_r[0]}), .dout(eye_dv)
  );

  lav_delay #(.W(3 * LAV_W), .D(T_TU - T_SIDE)) u_side_dly (
    .clk(clk), .en(en), .din({side_u[2], side_u[1], side_u[0]}), .dout(side_dv)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fwd_d[i]  = fwd_dv[i*LAV_W +: LAV_W];
      back_d[i] = back_dv[i*LAV_W +: LAV_W];
      eye_d[i]  = eye_dv[i*LAV_W +: LAV_W];
      side_d[i] = side_dv[i*LAV_W +: LAV_W];
    end
  end

  lav_cross u_cross_up (
    .clk(clk), .en(en), .a(side_u), .b(fwd_d), .o(traw)
  );

  always_comb begin : rnd_comb
    logic [LAV_XW-1:0] mg;
    logic [RQW-1:0]    qq;
    for (int i = 0; i < 3; i++) begin
      mg = traw[i][LAV_XW-1] ? LAV_XW'(-traw[i]) : LAV_XW'(traw[i]);
      qq = RQW'((mg + LAV_XW'(LAV_HALF)) >> LAV_FRAC);
      if (qq > ONE_Q) begin
        qq = ONE_Q;
      end
      tu_nxt[i] = traw[i][LAV_XW-1] ? -LAV_W'(qq) : LAV_W'(qq);
    end
  end

  lav_dot u_dot_side (
    .clk(clk), .en(en), .r(side_d), .e(eye_d), .y(shf[0])
  );

  lav_dot u_dot_up (
    .clk(clk), .en(en), .r(tu_r), .e(eye_d), .y(shf[1])
  );

  lav_dot u_dot_back (
    .clk(clk), .en(en), .r(back_d), .e(eye_d), .y(shf[2])
  );

  lav_delay #(.W(9 * LAV_W), .D(LAV_DOT_LAT)) u_rows_dly (
    .clk (clk),
    .en  (en),
    .din ({back_dv, tu_r[2], tu_r[1], tu_r[0], side_dv}),
    .dout(rows_o)
  );

  assign res = {shf[2], shf[1], shf[0], rows_o};

  assign push       = en && v_r[T_OUT];
  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (ob_cnt_r != 2'd0);
  assign out_tdata  = ob_r[0];

  always_ff @(posedge clk) begin
    if (push && (ob_cnt_r == 2'd0 || (ob_cnt_r == 2'd1 && pop))) begin
      ob_r[0] <= res;
    end else if (pop) begin
      ob_r[0] <= ob_r[1];
    end
    if (push && ob_cnt_r == 2'd1 && !pop) begin
      ob_r[1] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_cnt_r <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   ob_cnt_r <= ob_cnt_r + 2'd1;
        2'b01:   ob_cnt_r <= ob_cnt_r - 2'd1;
        default: ob_cnt_r <= ob_cnt_r;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ob_cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipeline valid bits moved during a stall");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v_r[0])
    else $error("accepted request missing from the pipeline");

  a_push_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[T_OUT] && en) |=> out_tvalid)
    else $error("finished result not presented");

endmodule
`default_nettype wire

FILE: rtl/lav_delay.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lav_delay: enabled shift line
// Carries side data alongside the arithmetic stages for a fixed depth.
// ----------------------------------------------------------------------------
module lav_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sr_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= din;
      for (int i = 1; i < D; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign dout = sr_r[D-1];

endmodule
`default_nettype wire

FILE: rtl/lav_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lav_isqrt: pipelined floor square root
// Digit-by-digit root of a 64-bit value, STEPS root bits per stage.
// ----------------------------------------------------------------------------
module lav_isqrt #(
  parameter int STEPS = 4
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [lav_pkg::LAV_SQ_W-1:0]      din,
  output logic [lav_pkg::LAV_ROOT_W-1:0]    dout
);
  import lav_pkg::*;

  localparam int STG = (LAV_ROOT_W + STEPS - 1) / STEPS;
  localparam int RW  = LAV_ROOT_W + 2;
  localparam int TW  = RW + 2;
  localparam int SW  = LAV_SQ_W;

  logic [RW-1:0]         rem_r    [STG];
  logic [LAV_ROOT_W-1:0] root_r   [STG];
  logic [SW-1:0]         src_r    [STG];
  logic [RW-1:0]         rem_nxt  [STG];
  logic [LAV_ROOT_W-1:0] root_nxt [STG];
  logic [SW-1:0]         src_nxt  [STG];

  always_comb begin : isq_comb
    logic [TW-1:0]         rt;
    logic [TW-1:0]         trial;
    logic [RW-1:0]         rem;
    logic [LAV_ROOT_W-1:0] root;
    logic [SW-1:0]         src;
    rt    = '0;
    trial = '0;
    for (int k = 0; k < STG; k++) begin
      if (k == 0) begin
        rem  = '0;
        root = '0;
        src  = din;
      end else begin
        rem  = rem_r[k-1];
        root = root_r[k-1];
        src  = src_r[k-1];
      end
      for (int j = 0; j < STEPS; j++) begin
        if (k * STEPS + j < LAV_ROOT_W) begin
          rt    = {rem, src[SW-1 -: 2]};
          trial = {2'b00, root, 2'b01};
          src   = {src[SW-3:0], 2'b00};
          if (rt >= trial) begin
            rt   = rt - trial;
            root = {root[LAV_ROOT_W-2:0], 1'b1};
          end else begin
            root = {root[LAV_ROOT_W-2:0], 1'b0};
          end
          rem = rt[RW-1:0];
        end
      end
      rem_nxt[k]  = rem;
      root_nxt[k] = root;
      src_nxt[k]  = src;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < STG; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        src_r[k]  <= src_nxt[k];
      end
    end
  end

  assign dout = root_r[STG-1];

endmodule
`default_nettype wire

FILE: rtl/lav_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lav_div: pipelined restoring divider
// Gives a 31-bit quotient whose dividend high half lies below the divisor.
// ----------------------------------------------------------------------------
module lav_div #(
  parameter int STEPS = 4
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [lav_pkg::LAV_NUM_W-1:0]   num,
  input  logic [lav_pkg::LAV_ROOT_W-1:0]  den,
  output logic [lav_pkg::LAV_QUO_W-1:0]   quo
);
  import lav_pkg::*;

  localparam int STG = (LAV_QUO_W + STEPS - 1) / STEPS;
  localparam int RW  = LAV_ROOT_W;
  localparam int QW  = LAV_QUO_W;

  logic [RW-1:0] rem_r   [STG];
  logic [QW-1:0] q_r     [STG];
  logic [QW-1:0] low_r   [STG];
  logic [RW-1:0] den_r   [STG];
  logic [RW-1:0] rem_nxt [STG];
  logic [QW-1:0] q_nxt   [STG];
  logic [QW-1:0] low_nxt [STG];
  logic [RW-1:0] den_nxt [STG];

  always_comb begin : div_comb
    logic [RW:0]   rt;
    logic [RW-1:0] rem;
    logic [QW-1:0] q;
    logic [QW-1:0] low;
    logic [RW-1:0] dd;
    rt = '0;
    for (int k = 0; k < STG; k++) begin
      if (k == 0) begin
        rem = RW'(num[LAV_NUM_W-1 -: QW]);
        low = num[QW-1:0];
        q   = '0;
        dd  = den;
      end else begin
        rem = rem_r[k-1];
        low = low_r[k-1];
        q   = q_r[k-1];
        dd  = den_r[k-1];
      end
      for (int j = 0; j < STEPS; j++) begin
        if (k * STEPS + j < QW) begin
          rt  = {rem, low[QW-1]};
          low = {low[QW-2:0], 1'b0};
          if (rt >= {1'b0, dd}) begin
            rt = rt - {1'b0, dd};
            q  = {q[QW-2:0], 1'b1};
          end else begin
            q  = {q[QW-2:0], 1'b0};
          end
          rem = rt[RW-1:0];
        end
      end
      rem_nxt[k] = rem;
      q_nxt[k]   = q;
      low_nxt[k] = low;
      den_nxt[k] = dd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < STG; k++) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
        low_r[k] <= low_nxt[k];
        den_r[k] <= den_nxt[k];
      end
    end
  end

  assign quo = q_r[STG-1];

endmodule
`default_nettype wire

FILE: rtl/lav_unit3.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lav_unit3: vector normalizer
// Scales a signed 3-vector to a Q1.30 unit vector; a zero vector stays zero.
// ----------------------------------------------------------------------------
module lav_unit3 #(
  parameter int IW    = 33,
  parameter int STEPS = 4
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [IW-1:0]  v [3],
  output lav_pkg::lav_q_t       o [3]
);
  import lav_pkg::*;

  localparam int AW      = $clog2(IW);
  localparam int ISQ_STG = (LAV_ROOT_W + STEPS - 1) / STEPS;
  localparam int DIV_STG = (LAV_QUO_W + STEPS - 1) / STEPS;

  logic [IW-1:0]        m1_nxt [3];
  logic [IW-1:0]        mx1_nxt;
  logic [IW-1:0]        m1_r [3];
  logic [2:0]           neg1_r;
  logic [IW-1:0]        mx1_r;
  logic [AW-1:0]        top_b;
  logic [IW-1:0]        m2_r [3];
  logic [2:0]           neg2_r;
  logic                 zero2_r;
  logic                 right2_r;
  logic [AW-1:0]        amt2_r;
  logic [LAV_NRM_W-1:0] n3_nxt [3];
  logic [LAV_NRM_W-1:0] n3_r [3];
  logic [2:0]           neg3_r;
  logic                 zero3_r;
  logic [LAV_SQ_W-1:0]  sq4_r [3];
  logic [LAV_SQ_W-1:0]  sum5_r;
  logic [LAV_ROOT_W-1:0] len;
  logic [3*LAV_NRM_W-1:0] n_dly;
  logic [LAV_NRM_W-1:0] nd [3];
  logic [3:0]           sgn_dly;
  logic [LAV_NUM_W-1:0] num6_r [3];
  logic [LAV_ROOT_W-1:0] den6_r;
  logic [LAV_QUO_W-1:0] q [3];
  lav_q_t               o_r [3];

  always_comb begin
    mx1_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      m1_nxt[i] = v[i][IW-1] ? -v[i] : v[i];
      if (m1_nxt[i] > mx1_nxt) begin
        mx1_nxt = m1_nxt[i];
      end
    end
  end

  always_comb begin
    top_b = '0;
    for (int b = 0; b < IW; b++) begin
      if (mx1_r[b]) begin
        top_b = AW'(b);
      end
    end
  end

  always_comb begin : shift_comb
    logic [IW-1:0] rs;
    logic [LAV_NRM_W-1:0] ls;
    for (int i = 0; i < 3; i++) begin
      rs = m2_r[i] >> amt2_r;
      ls = LAV_NRM_W'(m2_r[i]) << amt2_r;
      n3_nxt[i] = right2_r ? LAV_NRM_W'(rs) : ls;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1_r[i]   <= m1_nxt[i];
        neg1_r[i] <= v[i][IW-1];
        m2_r[i]   <= m1_r[i];
        n3_r[i]   <= n3_nxt[i];
        sq4_r[i]  <= LAV_SQ_W'(n3_r[i]) * LAV_SQ_W'(n3_r[i]);
        num6_r[i] <= (LAV_NUM_W'(nd[i]) << LAV_FRAC) + LAV_NUM_W'(len >> 1);
        if (sgn_dly[3]) begin
          o_r[i] <= '0;
        end else if (sgn_dly[i]) begin
          o_r[i] <= -LAV_W'(q[i]);
        end else begin
          o_r[i] <= LAV_W'(q[i]);
        end
      end
      mx1_r    <= mx1_nxt;
      neg2_r   <= neg1_r;
      zero2_r  <= (mx1_r == '0);
      right2_r <= (top_b > AW'(LAV_FRAC));
      amt2_r   <= (top_b > AW'(LAV_FRAC)) ? top_b - AW'(LAV_FRAC) : AW'(LAV_FRAC) - top_b;
      neg3_r   <= neg2_r;
      zero3_r  <= zero2_r;
      sum5_r   <= sq4_r[0] + sq4_r[1] + sq4_r[2];
      den6_r   <= len;
    end
  end

  lav_isqrt #(.STEPS(STEPS)) u_isqrt (
    .clk (clk),
    .en  (en),
    .din (sum5_r),
    .dout(len)
  );

  lav_delay #(.W(3 * LAV_NRM_W), .D(2 + ISQ_STG)) u_n_dly (
    .clk (clk),
    .en  (en),
    .din ({n3_r[2], n3_r[1], n3_r[0]}),
    .dout(n_dly)
  );

  lav_delay #(.W(4), .D(3 + ISQ_STG + DIV_STG)) u_sgn_dly (
    .clk (clk),
    .en  (en),
    .din ({zero3_r, neg3_r}),
    .dout(sgn_dly)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nd[i] = n_dly[i*LAV_NRM_W +: LAV_NRM_W];
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    lav_div #(.STEPS(STEPS)) u_div (
      .clk(clk),
      .en (en),
      .num(num6_r[g]),
      .den(den6_r),
      .quo(q[g])
    );
  end

  assign o = o_r;

endmodule
`default_nettype wire

FILE: rtl/lav_cross.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lav_cross: cross product of two Q1.30 vectors
// Products in the first stage, differences in the second, full Q2.60 result.
// ----------------------------------------------------------------------------
module lav_cross (
  input  logic                                clk,
  input  logic                                en,
  input  lav_pkg::lav_q_t                     a [3],
  input  lav_pkg::lav_q_t                     b [3],
  output logic signed [lav_pkg::LAV_XW-1:0]   o [3]
);
  import lav_pkg::*;

  localparam int FW = 2 * LAV_W;

  logic signed [LAV_XP_W-1:0] p_r [6];
  logic signed [LAV_XW-1:0]   o_r [3];

  function automatic logic signed [LAV_XP_W-1:0] mulq(lav_q_t x, lav_q_t y);
    logic signed [FW-1:0] f;
    f = FW'(x) * FW'(y);
    return f[LAV_XP_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= mulq(a[1], b[2]);
      p_r[1] <= mulq(a[2], b[1]);
      p_r[2] <= mulq(a[2], b[0]);
      p_r[3] <= mulq(a[0], b[2]);
      p_r[4] <= mulq(a[0], b[1]);
      p_r[5] <= mulq(a[1], b[0]);
      for (int i = 0; i < 3; i++) begin
        o_r[i] <= LAV_XW'(p_r[2*i]) - LAV_XW'(p_r[2*i+1]);
      end
    end
  end

  assign o = o_r;

endmodule
`default_nettype wire

FILE: rtl/lav_dot.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lav_dot: translation term of one matrix row
// Dot product of a Q1.30 row with the negated eye, rounded and saturated.
// ----------------------------------------------------------------------------
module lav_dot (
  input  logic             clk,
  input  logic             en,
  input  lav_pkg::lav_q_t  r [3],
  input  lav_pkg::lav_q_t  e [3],
  output lav_pkg::lav_q_t  y
);
  import lav_pkg::*;

  localparam int DW = 2 * LAV_W + 1;
  localparam int AW = 2 * LAV_W;
  localparam int QW = AW - LAV_FRAC;
  localparam logic [QW-1:0] QMIN = QW'(1) << (LAV_W - 1);
  localparam logic [QW-1:0] QMAX = QMIN - QW'(1);

  logic signed [LAV_XW-1:0] p1_r [3];
  logic signed [AW-1:0]     acc2_r;
  lav_q_t                   y_r;
  logic [AW-1:0]            mg;
  logic [QW-1:0]            qq;
  lav_q_t                   y_nxt;

  function automatic logic signed [LAV_XW-1:0] mul_neg(lav_q_t x, lav_q_t ev);
    logic signed [DW-1:0] f;
    f = DW'(x) * (-DW'(ev));
    return f[LAV_XW-1:0];
  endfunction

  always_comb begin
    mg = acc2_r[AW-1] ? AW'(-acc2_r) : AW'(acc2_r);
    qq = QW'((mg + LAV_HALF) >> LAV_FRAC);
    if (acc2_r[AW-1]) begin
      y_nxt = (qq > QMIN) ? -LAV_W'(QMIN) : -LAV_W'(qq);
    end else begin
      y_nxt = (qq > QMAX) ? LAV_W'(QMAX) : LAV_W'(qq);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_r[i] <= mul_neg(r[i], e[i]);
      end
      acc2_r <= AW'(p1_r[0]) + AW'(p1_r[1]) + AW'(p1_r[2]);
      y_r    <= y_nxt;
    end
  end

  assign y = y_r;

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for look_at_view_matrix
// Streams camera setups into the block with random gaps and output stalls,
// computes each view matrix independently and compares every field in order.
// ----------------------------------------------------------------------------
module testbench;

  typedef longint v3_t [3];

  localparam int N_RANDOM   = 2000;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 600;

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [lav_pkg::LAV_IN_W-1:0]  in_tdata;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [lav_pkg::LAV_OUT_W-1:0] out_tdata;

  logic [lav_pkg::LAV_IN_W-1:0]  camera_queue[$];
  logic [lav_pkg::LAV_OUT_W-1:0] matrix_queue[$];
  int n_directed, n_requests, n_taken, n_matrices, n_errors, idle_cycles;
  int in_gap, out_gap, hold_cnt;
  bit held;

  look_at_view_matrix DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic normalize(input v3_t v, output v3_t o);
    longint unsigned m[3];
    longint unsigned mx, sum, len, q;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = magnitude(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return;
    end
    while (mx >= (64'd1 << 31)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (len >> 1)) / len;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endtask

  task automatic cross3(input v3_t a, input v3_t b, output v3_t o);
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
  endtask

  function automatic logic [31:0] round_q30(longint x);
    longint unsigned q;
    q = (magnitude(x) + (64'd1 << 29)) >> 30;
    if (q > (64'd1 << 30)) q = 64'd1 << 30;
    return x < 0 ? 32'(-longint'(q)) : 32'(q);
  endfunction

  function automatic logic [31:0] round_shift(longint x);
    longint unsigned q;
    q = (magnitude(x) + (64'd1 << 29)) >> 30;
    if (x < 0) begin
      if (q > (64'd1 << 31)) q = 64'd1 << 31;
      return 32'(-longint'(q));
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return 32'(q);
  endfunction

  task automatic view_matrix(input logic [lav_pkg::LAV_IN_W-1:0] cam,
                             output logic [lav_pkg::LAV_OUT_W-1:0] mat);
    v3_t eye, fwd_raw, up_raw, fwd, up, side_raw, side, tu_raw, tu, back;
    longint acc;
    for (int i = 0; i < 3; i++) begin
      eye[i]     = longint'($signed(cam[32*i +: 32]));
      fwd_raw[i] = longint'($signed(cam[32*(3+i) +: 32])) - eye[i];
      up_raw[i]  = longint'($signed(cam[32*(6+i) +: 32]));
    end
    normalize(fwd_raw, fwd);
    normalize(up_raw, up);
    cross3(fwd, up, side_raw);
    normalize(side_raw, side);
    cross3(side, fwd, tu_raw);
    for (int i = 0; i < 3; i++) begin
      tu[i] = longint'($signed(round_q30(tu_raw[i])));
      back[i] = -fwd[i];
      mat[32*i +: 32]     = 32'(side[i]);
      mat[32*(3+i) +: 32] = 32'(tu[i]);
      mat[32*(6+i) +: 32] = 32'(back[i]);
    end
    acc = -(side[0] * eye[0] + side[1] * eye[1] + side[2] * eye[2]);
    mat[32*9 +: 32] = round_shift(acc);
    acc = -(tu[0] * eye[0] + tu[1] * eye[1] + tu[2] * eye[2]);
    mat[32*10 +: 32] = round_shift(acc);
    acc = -(back[0] * eye[0] + back[1] * eye[1] + back[2] * eye[2]);
    mat[32*11 +: 32] = round_shift(acc);
  endtask

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] coord(int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2 * 65536 * 100)) - 65536 * 100);
      2: return 32'($signed($urandom_range(0, 64)) - 32);
      default: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
    endcase
  endfunction

  function automatic logic [lav_pkg::LAV_IN_W-1:0] camera(
      logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
      logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
      logic [31:0] ux, logic [31:0] uy, logic [31:0] uz);
    return {uz, uy, ux, tz, ty, tx, ez, ey, ex};
  endfunction

  task automatic add_camera(input logic [lav_pkg::LAV_IN_W-1:0] c);
    camera_queue.push_back(c);
  endtask

  initial begin
    logic [31:0] e[3], t[3], u[3];
    int kind, shape, k;
    rst_n = 1'b0;
    // Zero vectors, eye on target, up along forward, extremes and a classic camera.
    add_camera('0);
    add_camera(camera(1, 2, 3, 1, 2, 3, 0, 32'h10000, 0));
    add_camera(camera(0, 0, 0, 0, 0, 32'hFFFF0000, 0, 32'h10000, 0));
    add_camera(camera(0, 0, 32'h50000, 0, 0, 0, 0, 32'h10000, 0));
    add_camera(camera(0, 0, 0, 32'h10000, 0, 0, 32'h30000, 0, 0));
    add_camera(camera(0, 0, 0, 32'h10000, 0, 0, 32'hFFFD0000, 0, 0));
    add_camera(camera(0, 0, 0, 0, 32'h10000, 0, 0, 0, 0));
    add_camera(camera(32'h80000000, 32'h80000000, 32'h80000000,
                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      32'h80000000, 32'h7FFFFFFF, 32'h80000000));
    add_camera(camera(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                      32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    add_camera(camera(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 1, 0));
    add_camera(camera(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 1, 0, 0));
    add_camera(camera(0, 0, 0, 1, 0, 0, 0, 0, 1));
    add_camera(camera(32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 0));
    add_camera(camera(32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 0, 0, 0, 32'h7FFFFFFF));
    add_camera(camera(32'h00A00000, 32'h00500000, 32'h00A00000, 0, 0, 0,
                      0, 32'h10000, 0));
    add_camera(camera(3, 4, 0, 0, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
    add_camera(camera(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
    n_directed = camera_queue.size();
    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 3);
      shape = $urandom_range(0, 19);
      for (int i = 0; i < 3; i++) begin
        e[i] = coord(kind);
        t[i] = coord(kind);
        u[i] = coord($urandom_range(0, 3));
      end
      if (shape == 0) begin
        t = e;
      end else if (shape == 1) begin
        k = $urandom_range(1, 8);
        for (int i = 0; i < 3; i++) begin
          u[i] = 32'(($signed(t[i]) - $signed(e[i])) * k);
        end
        if (kind == 0 || kind == 3) u = t;
      end else if (shape == 2) begin
        u[0] = 0; u[1] = 0; u[2] = 0;
      end
      add_camera(camera(e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2]));
    end
    n_requests = camera_queue.size();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (n_taken < n_requests || matrix_queue.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Checked %0d view matrices from %0d directed and %0d random camera setups,",
             n_matrices, n_directed, n_requests - n_directed);
    $display("including a long output stall of %0d cycles; %0d field mismatches.",
             HOLD_LEN, n_errors);
    if (n_errors == 0 && matrix_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (camera_queue.size() > 0) begin
        in_tdata <= camera_queue.pop_front();
        in_tvalid <= 1'b1;
        in_gap <= next_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
      hold_cnt <= 0;
      held <= 1'b0;
    end else if (!held && n_taken >= 400) begin
      held <= 1'b1;
      hold_cnt <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_gap <= next_gap();
    end
  end

  always @(posedge clk) begin
    logic [lav_pkg::LAV_OUT_W-1:0] mat;
    string names[12];
    names = '{"side_x", "side_y", "side_z", "true_up_x", "true_up_y", "true_up_z",
              "back_x", "back_y", "back_z", "shift_x", "shift_y", "shift_z"};
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        view_matrix(in_tdata, mat);
        matrix_queue.push_back(mat);
        n_taken++;
      end
      if (out_tvalid && out_tready) begin
        n_matrices++;
        if (matrix_queue.size() == 0) begin
          $error("view matrix returned with no request outstanding");
          n_errors++;
        end else begin
          mat = matrix_queue.pop_front();
          for (int i = 0; i < 12; i++) begin
            if (out_tdata[32*i +: 32] !== mat[32*i +: 32]) begin
              $error("%s: expected %0d, got %0d", names[i],
                     $signed(mat[32*i +: 32]), $signed(out_tdata[32*i +: 32]));
              n_errors++;
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_tvalid && in_tready) || (out_tvalid && out_tready))) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no request or result moved for %0d cycles.", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

endmodule
